// File: rtl/nnis_pkg.sv
package nnis_pkg;

   localparam int MAX_SRC_DIM = 64;
   localparam int MAX_DST_DIM = 64;

   localparam int CFG_W       = 7;
   localparam int COORD_W     = 6;
   localparam int COLOR_W     = 8;
   localparam int RGB_W       = 3 * COLOR_W;
   localparam int STORE_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int NUM_W       = COORD_W + CFG_W;
   localparam int DIV_CNT_W   = $clog2(NUM_W);

   localparam logic [COLOR_W-1:0] COLOR_FULL   = '1;
   localparam logic [COLOR_W-1:0] COLOR_NONE   = '0;
   localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = '1;
   localparam logic [COLOR_W-1:0] ALPHA_CLEAR  = '0;

   typedef enum logic [1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_EMIT = 1'b1
   } func_type;

   typedef enum logic {
      AXIS_X = 1'b0,
      AXIS_Y = 1'b1
   } axis_type;

   typedef struct packed {
      logic     load;
      logic     emit_begin;
      logic     div_start;
      axis_type div_axis;
      logic     xs_capture;
      logic     ys_capture;
      logic     addr_load;
      logic     mem_read;
      logic     rsp_fire;
      logic     rsp_empty;
   } nnis_cmd_type;

   typedef struct packed {
      logic empty;
      logic div_done;
   } nnis_status_type;

endpackage

// File: rtl/nnis_div.sv
module nnis_div
   import nnis_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   numerator,
   input  logic [CFG_W-1:0]   divisor,
   output logic [NUM_W-1:0]   quotient,
   output logic               done
);

   logic [CFG_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [CFG_W-1:0]     div_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 run_ff;
   logic                 done_ff;
   logic [CFG_W:0]       trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = CFG_W'(trial - {1'b0, div_ff});
         num_in = {num_ff[NUM_W-2:0], 1'b1};
      end else begin
         rem_in = trial[CFG_W-1:0];
         num_in = {num_ff[NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         num_ff <= numerator;
         div_ff <= divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
      end
   end

   assign quotient = num_ff;
   assign done     = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff)
      else $error("divider restarted while running");

endmodule

// File: rtl/nnis_dp.sv
module nnis_dp
   import nnis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  nnis_cmd_type          cmd,
   output nnis_status_type       status,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic [COLOR_W-1:0]    req_in_red,
   input  logic [COLOR_W-1:0]    req_in_green,
   input  logic [COLOR_W-1:0]    req_in_blue,
   output logic                  rsp_strobe,
   output logic [COORD_W-1:0]    rsp_dst_x,
   output logic [COORD_W-1:0]    rsp_dst_y,
   output logic [COLOR_W-1:0]    rsp_out_red,
   output logic [COLOR_W-1:0]    rsp_out_green,
   output logic [COLOR_W-1:0]    rsp_out_blue,
   output logic [COLOR_W-1:0]    rsp_out_alpha,
   output logic                  rsp_last_pixel
);

   logic [CFG_W-1:0]   src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic [CFG_W-1:0]   sw, sh, dw, dh;
   logic [ADDR_W:0]    total;
   logic [ADDR_W-1:0]  load_ff, load_eff, load_in;
   logic [COORD_W-1:0] col_ff, row_ff, col_eff, row_eff;
   logic [COORD_W-1:0] x_ff, y_ff, xs_ff, ys_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [NUM_W-1:0]   addr_full;
   logic [RGB_W-1:0]   rd_ff;
   logic [NUM_W-1:0]   div_num, quotient;
   logic [CFG_W-1:0]   div_den;
   logic [CFG_W-1:0]   x_next, y_next;
   logic               last_in;
   logic               div_done;

   logic               strobe_ff;
   logic [COORD_W-1:0] out_x_ff, out_y_ff;
   logic [COLOR_W-1:0] out_r_ff, out_g_ff, out_b_ff, out_a_ff;
   logic               out_last_ff;

   logic [RGB_W-1:0]   store_mem [STORE_DEPTH];

   function automatic logic [CFG_W-1:0] clamp_src(input logic [CFG_W-1:0] v);
      if (v == '0)
         return CFG_W'(1);
      else if (v > CFG_W'(MAX_SRC_DIM))
         return CFG_W'(MAX_SRC_DIM);
      else
         return v;
   endfunction

   always_comb begin
      sw = clamp_src(src_width_ff);
      sh = clamp_src(src_height_ff);
      dw = (dst_width_ff  > CFG_W'(MAX_DST_DIM)) ? CFG_W'(MAX_DST_DIM) : dst_width_ff;
      dh = (dst_height_ff > CFG_W'(MAX_DST_DIM)) ? CFG_W'(MAX_DST_DIM) : dst_height_ff;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= CFG_W'(64);
         src_height_ff <= CFG_W'(64);
         dst_width_ff  <= CFG_W'(64);
         dst_height_ff <= CFG_W'(64);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata;
            CSR_DST_HEIGHT: dst_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // load side: restart the raster index if the source size shrank
   always_comb begin
      total    = (ADDR_W + 1)'(sw) * (ADDR_W + 1)'(sh);
      load_eff = ({1'b0, load_ff} >= total) ? '0 : load_ff;
      load_in  = ({1'b0, load_eff} + 1'b1 >= total) ? '0 : load_eff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.load)
         store_mem[load_eff] <= {req_in_red, req_in_green, req_in_blue};
      if (cmd.mem_read)
         rd_ff <= store_mem[addr_ff];
   end

   // emit counters
   always_comb begin
      col_eff = ({1'b0, col_ff} >= dw) ? '0 : col_ff;
      row_eff = ({1'b0, row_ff} >= dh) ? '0 : row_ff;
      x_next  = {1'b0, x_ff} + 1'b1;
      y_next  = {1'b0, y_ff} + 1'b1;
      last_in = (x_next == dw) && (y_next == dh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         if (cmd.load)
            load_ff <= load_in;
         if (cmd.rsp_empty) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (cmd.rsp_fire) begin
            // rows advance first, then the column
            if (y_next >= dh) begin
               row_ff <= '0;
               col_ff <= (x_next >= dw) ? '0 : x_next[COORD_W-1:0];
            end else begin
               row_ff <= y_next[COORD_W-1:0];
               col_ff <= x_ff;
            end
         end
      end
   end

   // source coordinate: floor(dst * src / dst_size)
   always_comb begin
      if (cmd.div_axis == AXIS_Y) begin
         div_num = NUM_W'(y_ff) * NUM_W'(sh);
         div_den = dh;
      end else begin
         div_num = NUM_W'(x_ff) * NUM_W'(sw);
         div_den = dw;
      end
      addr_full = NUM_W'(ys_ff) * NUM_W'(sw) + NUM_W'(xs_ff);
   end

   nnis_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .numerator (div_num),
      .divisor   (div_den),
      .quotient  (quotient),
      .done      (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.emit_begin) begin
         x_ff <= col_eff;
         y_ff <= row_eff;
      end
      if (cmd.xs_capture)
         xs_ff <= quotient[COORD_W-1:0];
      if (cmd.ys_capture)
         ys_ff <= quotient[COORD_W-1:0];
      if (cmd.addr_load)
         addr_ff <= addr_full[ADDR_W-1:0];
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset)
         strobe_ff <= 1'b0;
      else
         strobe_ff <= cmd.rsp_fire | cmd.rsp_empty;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_empty) begin
         out_x_ff    <= '0;
         out_y_ff    <= '0;
         out_r_ff    <= COLOR_NONE;
         out_g_ff    <= COLOR_NONE;
         out_b_ff    <= COLOR_NONE;
         out_a_ff    <= ALPHA_CLEAR;
         out_last_ff <= 1'b1;
      end else if (cmd.rsp_fire) begin
         out_x_ff    <= x_ff;
         out_y_ff    <= y_ff;
         out_last_ff <= last_in;
         // pure black turns into transparent white
         if (rd_ff == '0) begin
            out_r_ff <= COLOR_FULL;
            out_g_ff <= COLOR_FULL;
            out_b_ff <= COLOR_FULL;
            out_a_ff <= ALPHA_CLEAR;
         end else begin
            out_r_ff <= rd_ff[RGB_W-1 -: COLOR_W];
            out_g_ff <= rd_ff[COLOR_W +: COLOR_W];
            out_b_ff <= rd_ff[COLOR_W-1:0];
            out_a_ff <= ALPHA_OPAQUE;
         end
      end
   end

   assign status.empty    = (dw == '0) || (dh == '0);
   assign status.div_done = div_done;

   assign rsp_strobe     = strobe_ff;
   assign rsp_dst_x      = out_x_ff;
   assign rsp_dst_y      = out_y_ff;
   assign rsp_out_red    = out_r_ff;
   assign rsp_out_green  = out_g_ff;
   assign rsp_out_blue   = out_b_ff;
   assign rsp_out_alpha  = out_a_ff;
   assign rsp_last_pixel = out_last_ff;

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_fire && last_in |=> col_ff == '0 && row_ff == '0)
      else $error("emit counters did not wrap after last pixel");

   a_fire_strobes: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_fire |=> rsp_strobe && !rsp_last_pixel == !$past(last_in))
      else $error("result word missing or last flag wrong");

endmodule

// File: rtl/nnis_ctrl.sv
module nnis_ctrl
   import nnis_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  func_type        func,
   input  nnis_status_type status,
   output nnis_cmd_type    cmd,
   output logic            busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START_X,
      ST_WAIT_X,
      ST_START_Y,
      ST_WAIT_Y,
      ST_ADDR,
      ST_READ,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (func == FUNC_LOAD) begin
                  cmd.load = 1'b1;
               end else if (status.empty) begin
                  cmd.rsp_empty = 1'b1;
               end else begin
                  cmd.emit_begin = 1'b1;
                  state_in       = ST_START_X;
               end
            end
         end
         ST_START_X: begin
            cmd.div_start = 1'b1;
            cmd.div_axis  = AXIS_X;
            state_in      = ST_WAIT_X;
         end
         ST_WAIT_X: begin
            if (status.div_done) begin
               cmd.xs_capture = 1'b1;
               state_in       = ST_START_Y;
            end
         end
         ST_START_Y: begin
            cmd.div_start = 1'b1;
            cmd.div_axis  = AXIS_Y;
            state_in      = ST_WAIT_Y;
         end
         ST_WAIT_Y: begin
            cmd.div_axis = AXIS_Y;
            if (status.div_done) begin
               cmd.ys_capture = 1'b1;
               state_in       = ST_ADDR;
            end
         end
         ST_ADDR: begin
            cmd.addr_load = 1'b1;
            state_in      = ST_READ;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            cmd.rsp_fire = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

   a_begin_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_begin |=> busy && state_ff == ST_START_X)
      else $error("emit did not start the divide sequence");

   a_wait_y_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT_Y && status.div_done |=> state_ff == ST_ADDR)
      else $error("row quotient dropped");

endmodule

// File: rtl/nearest_neighbor_image_scaler.sv
// channel   ports                                   handshake
// request   req_func, req_in_red/green/blue         start & !busy
// response  rsp_dst_x/y, rsp_out_*, rsp_last_pixel  rsp_strobe, one cycle
// config    csr_index, csr_wdata                    csr_we
//
// A load word is taken in the idle state and leaves busy low.
// An empty-destination emit answers in the following cycle and leaves busy low.
// A normal emit holds busy while the bit-serial divider runs once per axis, then
// through the address, read and output states; the word appears the cycle busy falls.
// Synchronous reset restores the sizes to 64 and clears all counters.
// The receiver cannot stall: each response word is shown for one cycle only.
module nearest_neighbor_image_scaler
   import nnis_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [COLOR_W-1:0] req_in_red,
   input  logic [COLOR_W-1:0] req_in_green,
   input  logic [COLOR_W-1:0] req_in_blue,
   output logic               rsp_strobe,
   output logic [COORD_W-1:0] rsp_dst_x,
   output logic [COORD_W-1:0] rsp_dst_y,
   output logic [COLOR_W-1:0] rsp_out_red,
   output logic [COLOR_W-1:0] rsp_out_green,
   output logic [COLOR_W-1:0] rsp_out_blue,
   output logic [COLOR_W-1:0] rsp_out_alpha,
   output logic               rsp_last_pixel,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [CFG_W-1:0]   csr_wdata
);

   nnis_cmd_type    cmd;
   nnis_status_type status;

   nnis_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .func   (func_type'(req_func)),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   nnis_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (csr_index_type'(csr_index)),
      .csr_wdata      (csr_wdata),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_strobe     (rsp_strobe),
      .rsp_dst_x      (rsp_dst_x),
      .rsp_dst_y      (rsp_dst_y),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_alpha  (rsp_out_alpha),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule

// File: dv/tb_nearest_neighbor_image_scaler.sv
module tb_nearest_neighbor_image_scaler;
   timeunit 1ns;
   timeprecision 1ps;

   import nnis_pkg::*;

   localparam int CYCLE_LIMIT     = 500_000;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int MAX_PRINTED     = 40;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] alpha;
      logic               last;
   } pixel_word_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   func_type           req_func;
   logic [COLOR_W-1:0] req_in_red;
   logic [COLOR_W-1:0] req_in_green;
   logic [COLOR_W-1:0] req_in_blue;
   logic               rsp_strobe;
   logic [COORD_W-1:0] rsp_dst_x;
   logic [COORD_W-1:0] rsp_dst_y;
   logic [COLOR_W-1:0] rsp_out_red;
   logic [COLOR_W-1:0] rsp_out_green;
   logic [COLOR_W-1:0] rsp_out_blue;
   logic [COLOR_W-1:0] rsp_out_alpha;
   logic               rsp_last_pixel;
   logic               csr_we;
   csr_index_type      csr_index;
   logic [CFG_W-1:0]   csr_wdata;

   nearest_neighbor_image_scaler u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_in_red     (req_in_red),
      .req_in_green   (req_in_green),
      .req_in_blue    (req_in_blue),
      .rsp_strobe     (rsp_strobe),
      .rsp_dst_x      (rsp_dst_x),
      .rsp_dst_y      (rsp_dst_y),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_alpha  (rsp_out_alpha),
      .rsp_last_pixel (rsp_last_pixel),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // scaler state as the testbench sees it
   logic [RGB_W-1:0] frame_copy [STORE_DEPTH];
   bit               frame_written [STORE_DEPTH];
   int               load_ptr = 0;
   int               emit_col = 0;
   int               emit_row = 0;
   logic [CFG_W-1:0] size_reg [4];
   pixel_word_type   pending_pixels [$];

   int gap_pct        = 0;
   int loads_sent     = 0;
   int emits_sent     = 0;
   int empty_expected = 0;
   int size_settings  = 0;
   int pixels_checked = 0;
   int frames_closed  = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int clamp_src_size(logic [CFG_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_SRC_DIM) return MAX_SRC_DIM;
      return value;
   endfunction

   function automatic int clamp_dst_size(logic [CFG_W-1:0] value);
      if (value > MAX_DST_DIM) return MAX_DST_DIM;
      return value;
   endfunction

   // raster address of the source pixel nearest to destination (x, y)
   function automatic int source_addr(int x, int y);
      int sw, sh, dw, dh;
      sw = clamp_src_size(size_reg[CSR_SRC_WIDTH]);
      sh = clamp_src_size(size_reg[CSR_SRC_HEIGHT]);
      dw = clamp_dst_size(size_reg[CSR_DST_WIDTH]);
      dh = clamp_dst_size(size_reg[CSR_DST_HEIGHT]);
      return ((y * sh / dh) * sw + x * sw / dw) % STORE_DEPTH;
   endfunction

   // true when the destination is empty or the next emit reads a store entry that holds a loaded pixel
   function automatic bit emit_source_ready();
      int dw, dh;
      dw = clamp_dst_size(size_reg[CSR_DST_WIDTH]);
      dh = clamp_dst_size(size_reg[CSR_DST_HEIGHT]);
      if (dw == 0 || dh == 0) return 1'b1;
      return frame_written[source_addr(emit_col >= dw ? 0 : emit_col,
                                       emit_row >= dh ? 0 : emit_row)];
   endfunction

   function automatic void resample_step(func_type func, logic [COLOR_W-1:0] red,
                                         logic [COLOR_W-1:0] green,
                                         logic [COLOR_W-1:0] blue);
      int               sw, sh, dw, dh, total;
      logic [RGB_W-1:0] rgb;
      pixel_word_type   word;
      sw = clamp_src_size(size_reg[CSR_SRC_WIDTH]);
      sh = clamp_src_size(size_reg[CSR_SRC_HEIGHT]);
      dw = clamp_dst_size(size_reg[CSR_DST_WIDTH]);
      dh = clamp_dst_size(size_reg[CSR_DST_HEIGHT]);
      if (func == FUNC_LOAD) begin
         total = sw * sh;
         if (load_ptr >= total) load_ptr = 0;
         frame_copy[load_ptr]    = {red, green, blue};
         frame_written[load_ptr] = 1'b1;
         load_ptr = (load_ptr + 1 >= total) ? 0 : load_ptr + 1;
         return;
      end
      // empty destination: one clear pixel at the origin, counters parked
      if (dw == 0 || dh == 0) begin
         emit_col = 0;
         emit_row = 0;
         word = '0;
         word.last = 1'b1;
         pending_pixels = {pending_pixels, word};
         empty_expected++;
         return;
      end
      if (emit_col >= dw) emit_col = 0;
      if (emit_row >= dh) emit_row = 0;
      rgb = frame_copy[source_addr(emit_col, emit_row)];
      word.x = COORD_W'(emit_col);
      word.y = COORD_W'(emit_row);
      if (rgb == '0)
         {word.red, word.green, word.blue, word.alpha} =
            {COLOR_FULL, COLOR_FULL, COLOR_FULL, ALPHA_CLEAR};
      else
         {word.red, word.green, word.blue, word.alpha} = {rgb, ALPHA_OPAQUE};
      word.last = (emit_col + 1 == dw) && (emit_row + 1 == dh);
      // rows advance first, then columns
      if (emit_row + 1 >= dh) begin
         emit_row = 0;
         emit_col = (emit_col + 1 >= dw) ? 0 : emit_col + 1;
      end else begin
         emit_row++;
      end
      pending_pixels = {pending_pixels, word};
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t ns: pixel %0d %s mismatch: got %0d, expected %0d",
                  $time, pixels_checked, field, got, want);
   endtask

   always @(posedge clock) begin : check_pixels
      pixel_word_type want;
      if (!reset && rsp_strobe) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unrequested word, dst_x", rsp_dst_x, -1);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_dst_x !== want.x) report_mismatch("dst_x", rsp_dst_x, want.x);
            if (rsp_dst_y !== want.y) report_mismatch("dst_y", rsp_dst_y, want.y);
            if (rsp_out_red !== want.red)
               report_mismatch("out_red", rsp_out_red, want.red);
            if (rsp_out_green !== want.green)
               report_mismatch("out_green", rsp_out_green, want.green);
            if (rsp_out_blue !== want.blue)
               report_mismatch("out_blue", rsp_out_blue, want.blue);
            if (rsp_out_alpha !== want.alpha)
               report_mismatch("out_alpha", rsp_out_alpha, want.alpha);
            if (rsp_last_pixel !== want.last)
               report_mismatch("last_pixel", rsp_last_pixel, want.last);
            if (want.last) frames_closed++;
            pixels_checked++;
         end
      end
   end

   task automatic send_word(func_type func, logic [COLOR_W-1:0] red,
                            logic [COLOR_W-1:0] green, logic [COLOR_W-1:0] blue);
      int gap;
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         gap = $urandom_range(1, 36);
         @(negedge clock) start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start        <= 1'b1;
      req_func     <= func;
      req_in_red   <= red;
      req_in_green <= green;
      req_in_blue  <= blue;
      // hold the word until the scaler takes it
      do @(posedge clock); while (busy);
      resample_step(func, red, green, blue);
      if (func == FUNC_LOAD) loads_sent++;
      else emits_sent++;
   endtask

   task automatic send_load(logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
                            logic [COLOR_W-1:0] blue);
      send_word(FUNC_LOAD, red, green, blue);
   endtask

   task automatic send_emit();
      send_word(FUNC_EMIT, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
   endtask

   function automatic logic [COLOR_W-1:0] pick_channel();
      case ($urandom_range(7))
         0: return COLOR_NONE;
         1: return COLOR_FULL;
         default: return COLOR_W'($urandom);
      endcase
   endfunction

   task automatic send_random_load();
      if ($urandom_range(5) == 0)
         send_load(COLOR_NONE, COLOR_NONE, COLOR_NONE);
      else
         send_load(pick_channel(), pick_channel(), pick_channel());
   endtask

   // drop start, wait out every pending pixel and let a trailing load settle
   task automatic stop_and_drain();
      @(negedge clock) start <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_size(csr_index_type idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock) csr_we <= 1'b0;
      size_reg[idx] = value;
   endtask

   task automatic set_sizes(logic [CFG_W-1:0] sw, logic [CFG_W-1:0] sh,
                            logic [CFG_W-1:0] dw, logic [CFG_W-1:0] dh);
      write_size(CSR_SRC_WIDTH, sw);
      write_size(CSR_SRC_HEIGHT, sh);
      write_size(CSR_DST_WIDTH, dw);
      write_size(CSR_DST_HEIGHT, dh);
      size_settings++;
   endtask

   function automatic logic [CFG_W-1:0] pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 4) return 0;
      if (roll < 8) return 64;
      if (roll < 12) return CFG_W'($urandom_range(65, 127));
      if (roll < 16) return CFG_W'($urandom_range(9, 63));
      return CFG_W'($urandom_range(1, 8));
   endfunction

   // 2x2 source upscaled to 3x2, one full frame and the wrap to the origin
   task automatic test_load_and_emit();
      set_sizes(2, 2, 3, 2);
      send_load(COLOR_NONE, COLOR_NONE, COLOR_NONE);
      send_load(COLOR_FULL, COLOR_FULL, COLOR_FULL);
      send_load(COLOR_FULL, COLOR_NONE, COLOR_NONE);
      send_load(COLOR_NONE, COLOR_NONE, COLOR_FULL);
      repeat (7) send_emit();
      stop_and_drain();
   endtask

   // shrink the destination under the emit counters
   task automatic test_counter_restart();
      repeat (2) send_emit();
      stop_and_drain();
      write_size(CSR_DST_WIDTH, 1);
      write_size(CSR_DST_HEIGHT, 1);
      send_emit();
      stop_and_drain();
   endtask

   task automatic test_empty_destination();
      write_size(CSR_DST_WIDTH, 0);
      send_emit();
      stop_and_drain();
      write_size(CSR_DST_WIDTH, 3);
      write_size(CSR_DST_HEIGHT, 0);
      send_emit();
      stop_and_drain();
      write_size(CSR_DST_HEIGHT, 2);
      send_emit();
      stop_and_drain();
   endtask

   // zero source sizes act as one, oversized sizes act as the maximum
   task automatic test_size_clamp();
      set_sizes(0, 0, 127, 1);
      send_load(8'h07, 8'h80, 8'h40);
      repeat (3) send_emit();
      stop_and_drain();
      write_size(CSR_SRC_WIDTH, 127);
      write_size(CSR_SRC_HEIGHT, 1);
      send_emit();
      stop_and_drain();
   endtask

   task automatic test_random_traffic(int pct);
      int sent, burst, total, dst_pixels;
      gap_pct = pct;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
         stop_and_drain();
         set_sizes(pick_size(), pick_size(), pick_size(), pick_size());
         total = clamp_src_size(size_reg[CSR_SRC_WIDTH]) *
                 clamp_src_size(size_reg[CSR_SRC_HEIGHT]);
         dst_pixels = clamp_dst_size(size_reg[CSR_DST_WIDTH]) *
                      clamp_dst_size(size_reg[CSR_DST_HEIGHT]);
         // often a whole source frame followed by a whole destination frame
         if (total <= 64 && $urandom_range(1) == 1) begin
            repeat (total) begin
               send_random_load();
               sent++;
            end
            if (dst_pixels <= 64) begin
               repeat (dst_pixels) begin
                  send_emit();
                  sent++;
               end
            end
         end
         burst = $urandom_range(10, 40);
         repeat (burst) begin
            if ($urandom_range(99) < 60 && emit_source_ready()) send_emit();
            else send_random_load();
            sent++;
         end
      end
      stop_and_drain();
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped after %0d cycles, %0d pixels still pending",
               cycle_count, pending_pixels.size());
      $display("** nearest_neighbor_image_scaler: FAILED **");
      $finish;
   end

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_func     = FUNC_LOAD;
      req_in_red   = '0;
      req_in_green = '0;
      req_in_blue  = '0;
      csr_we       = 1'b0;
      csr_index    = CSR_SRC_WIDTH;
      csr_wdata    = '0;
      foreach (size_reg[i]) size_reg[i] = CFG_W'(64);
      gap_pct = 9;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_load_and_emit();
      test_counter_restart();
      test_empty_destination();
      test_size_clamp();
      test_random_traffic(9);
      test_random_traffic(56);
      test_random_traffic(0);

      repeat (40) @(posedge clock);
      $display("sent %0d loads and %0d emits over %0d size settings; checked %0d pixels",
               loads_sent, emits_sent, size_settings, pixels_checked);
      $display("(%0d from empty images, %0d frames closed), %0d mismatches",
               empty_expected, frames_closed, mismatch_count);
      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("** nearest_neighbor_image_scaler: PASSED **");
      end else begin
         $display("** nearest_neighbor_image_scaler: FAILED **");
      end
      $finish;
   end

endmodule
